FILE: design/ctrgb_pkg.sv
`default_nettype none

package ctrgb_pkg;

    // hue in q.16 units of hue, lightness in q.24
    localparam int HUE_W   = 19;
    localparam int ACC_W   = 21;
    localparam int CX_W    = 36;
    localparam int L_W     = 26;
    localparam int LIGHT_LAT = 64;

    localparam logic signed [ACC_W-1:0] HUE_MAX = 21'sd196608;
    localparam logic [19:0] HUE_ONE = 20'd65536;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic               sample_invalid;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } out_t;

    // atan(2^-i)*3/pi in q.16
    function automatic logic [15:0] atan_entry(logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd49152;
            5'd1:  v = 16'd29016;
            5'd2:  v = 16'd15331;
            5'd3:  v = 16'd7782;
            5'd4:  v = 16'd3906;
            5'd5:  v = 16'd1955;
            5'd6:  v = 16'd978;
            5'd7:  v = 16'd489;
            5'd8:  v = 16'd244;
            5'd9:  v = 16'd122;
            5'd10: v = 16'd61;
            5'd11: v = 16'd31;
            5'd12: v = 16'd15;
            5'd13: v = 16'd8;
            5'd14: v = 16'd4;
            5'd15: v = 16'd2;
            5'd16: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // 2^(2^-(idx+1)) in q.30
    function automatic logic [31:0] exp_entry(logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:  v = 32'd1518500250;
            4'd1:  v = 32'd1276901417;
            4'd2:  v = 32'd1170923762;
            4'd3:  v = 32'd1121280441;
            4'd4:  v = 32'd1097253712;
            4'd5:  v = 32'd1085434108;
            4'd6:  v = 32'd1079572136;
            4'd7:  v = 32'd1076653033;
            4'd8:  v = 32'd1075196444;
            4'd9:  v = 32'd1074468888;
            4'd10: v = 32'd1074105294;
            4'd11: v = 32'd1073923544;
            4'd12: v = 32'd1073832680;
            4'd13: v = 32'd1073787251;
            4'd14: v = 32'd1073764537;
            default: v = 32'd1073753181;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] chan_offset(logic [1:0] ch);
        logic [3:0] v;
        case (ch)
            CH_RED:   v = 4'd8;
            CH_GREEN: v = 4'd6;
            CH_BLUE:  v = 4'd10;
            default:  v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/ctrgb_cordic.sv
`default_nettype none

module ctrgb_cordic #(
    parameter int ITER = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [31:0]                real_part,
    input  wire logic signed [31:0]                imag_part,
    output logic                                   out_valid,
    output logic signed [ctrgb_pkg::HUE_W-1:0]     hue
);

    localparam int CW = ctrgb_pkg::CX_W;
    localparam int AW = ctrgb_pkg::ACC_W;
    localparam int HW = ctrgb_pkg::HUE_W;

    logic                 cv_reg [0:ITER];
    logic signed [CW-1:0] cx_reg [0:ITER];
    logic signed [CW-1:0] cy_reg [0:ITER];
    logic signed [AW-1:0] ca_reg [0:ITER];
    logic                 cz_reg [0:ITER];

    logic                 ov_reg;
    logic signed [HW-1:0] hue_reg;

    // half turn for the left half plane
    logic signed [CW-1:0] xs, ys;
    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [AW-1:0] a0_next;

    always_comb
    begin
        xs = CW'(real_part);
        ys = CW'(imag_part);
        if (real_part < 0)
        begin
            x0_next = -xs;
            y0_next = -ys;
            a0_next = (imag_part >= 0) ? ctrgb_pkg::HUE_MAX : -ctrgb_pkg::HUE_MAX;
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            a0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else
            cv_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= x0_next;
        cy_reg[0] <= y0_next;
        ca_reg[0] <= a0_next;
        cz_reg[0] <= (real_part == 0) && (imag_part == 0);
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;
        logic signed [AW-1:0] at;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        assign at = $signed({5'b0, ctrgb_pkg::atan_entry(5'(i))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cy_reg[i] < 0)
            begin
                cx_reg[i+1] <= cx_reg[i] - dx;
                cy_reg[i+1] <= cy_reg[i] + dy;
                ca_reg[i+1] <= ca_reg[i] - at;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] + dx;
                cy_reg[i+1] <= cy_reg[i] - dy;
                ca_reg[i+1] <= ca_reg[i] + at;
            end
            cz_reg[i+1] <= cz_reg[i];
        end
    end

    logic signed [AW-1:0] acc_c;

    always_comb
    begin
        acc_c = ca_reg[ITER];
        if (acc_c > ctrgb_pkg::HUE_MAX)
            acc_c = ctrgb_pkg::HUE_MAX;
        if (acc_c < -ctrgb_pkg::HUE_MAX)
            acc_c = -ctrgb_pkg::HUE_MAX;
        if (cz_reg[ITER])
            acc_c = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= cv_reg[ITER];
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= acc_c[HW-1:0];
    end

    assign out_valid = ov_reg;
    assign hue       = hue_reg;

endmodule

`default_nettype wire

FILE: design/ctrgb_light.sv
`default_nettype none

module ctrgb_light (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [63:0]                   s,
    input  wire logic [15:0]                   a,
    output logic                               out_valid,
    output logic [ctrgb_pkg::L_W-1:0]          l
);

    localparam int SQ_N = 16;
    localparam int EX_N = 16;
    localparam int DV_N = ctrgb_pkg::L_W;

    // leading one
    logic        v1_reg;
    logic [63:0] s1_reg;
    logic [5:0]  e1_reg;
    logic        z1_reg;
    logic [5:0]  e1_next;

    always_comb
    begin
        e1_next = '0;
        for (int b = 0; b < 64; b++)
            if (s[b])
                e1_next = 6'(b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s;
        e1_reg <= e1_next;
        z1_reg <= (s == 64'd0);
    end

    // normalise to q1.31, then fraction bits by squaring
    logic        sq_v_reg [0:SQ_N];
    logic [31:0] sq_m_reg [0:SQ_N];
    logic [15:0] sq_f_reg [0:SQ_N];
    logic [5:0]  sq_e_reg [0:SQ_N];
    logic        sq_z_reg [0:SQ_N];
    logic [31:0] m2_next;

    assign m2_next = (e1_reg >= 6'd31) ? 32'(s1_reg >> (e1_reg - 6'd31))
                                       : 32'(s1_reg << (6'd31 - e1_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else
            sq_v_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_m_reg[0] <= m2_next;
        sq_f_reg[0] <= '0;
        sq_e_reg[0] <= e1_reg;
        sq_z_reg[0] <= z1_reg;
    end

    for (genvar k = 1; k <= SQ_N; k++)
    begin : g_sq
        logic [63:0] prod;
        logic [32:0] sh;

        assign prod = sq_m_reg[k-1] * sq_m_reg[k-1];
        assign sh   = prod[63:31];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k] <= 1'b0;
            else
                sq_v_reg[k] <= sq_v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            sq_m_reg[k] <= sh[32] ? sh[32:1] : sh[31:0];
            sq_f_reg[k] <= sq_f_reg[k-1] | (sh[32] ? (16'd1 << (SQ_N - k)) : 16'd0);
            sq_e_reg[k] <= sq_e_reg[k-1];
            sq_z_reg[k] <= sq_z_reg[k-1];
        end
    end

    // a * 2*log2|z|
    logic               v19_reg;
    logic signed [39:0] p19_reg;
    logic               z19_reg;
    logic signed [22:0] t_c;
    logic signed [39:0] p19_next;

    assign t_c      = $signed({1'b0, sq_e_reg[SQ_N], sq_f_reg[SQ_N]}) - 23'sd2097152;
    assign p19_next = t_c * $signed({1'b0, a});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v19_reg <= 1'b0;
        else
            v19_reg <= sq_v_reg[SQ_N];
    end

    always_ff @(posedge clk)
    begin
        p19_reg <= p19_next;
        z19_reg <= sq_z_reg[SQ_N];
    end

    // scale and clamp to +-32
    logic signed [39:0] v_c;

    always_comb
    begin
        v_c = p19_reg >>> 13;
        if (v_c > 40'sd2097152)
            v_c = 40'sd2097152;
        if (v_c < -40'sd2097152)
            v_c = -40'sd2097152;
    end

    logic              ex_v_reg [0:EX_N];
    logic [31:0]       ex_m_reg [0:EX_N];
    logic [15:0]       ex_f_reg [0:EX_N];
    logic signed [6:0] ex_n_reg [0:EX_N];
    logic              ex_z_reg [0:EX_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ex_v_reg[0] <= 1'b0;
        else
            ex_v_reg[0] <= v19_reg;
    end

    always_ff @(posedge clk)
    begin
        ex_m_reg[0] <= 32'd1073741824;
        ex_f_reg[0] <= v_c[15:0];
        ex_n_reg[0] <= v_c[22:16];
        ex_z_reg[0] <= z19_reg;
    end

    // 2^frac as a product of table factors
    for (genvar k = 1; k <= EX_N; k++)
    begin : g_ex
        logic [63:0] prod;
        logic [63:0] rnd;

        assign prod = ex_m_reg[k-1] * ctrgb_pkg::exp_entry(4'(k - 1));
        assign rnd  = prod + 64'd536870912;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ex_v_reg[k] <= 1'b0;
            else
                ex_v_reg[k] <= ex_v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            ex_m_reg[k] <= ex_f_reg[k-1][EX_N-k] ? rnd[61:30] : ex_m_reg[k-1];
            ex_f_reg[k] <= ex_f_reg[k-1];
            ex_n_reg[k] <= ex_n_reg[k-1];
            ex_z_reg[k] <= ex_z_reg[k-1];
        end
    end

    // integer part shift, then the divisor and the rounded dividend
    logic [6:0]  nneg;
    logic [5:0]  amt;
    logic [63:0] mw, d_next, n_next;

    always_comb
    begin
        nneg   = 7'd0 - ex_n_reg[EX_N];
        amt    = ex_n_reg[EX_N][6] ? nneg[5:0] : ex_n_reg[EX_N][5:0];
        mw     = {32'b0, ex_m_reg[EX_N]};
        d_next = (ex_n_reg[EX_N][6] ? (mw >> amt) : (mw << amt)) + 64'd1073741824;
        n_next = 64'h0080_0000_0000_0000 + (d_next >> 1);
    end

    logic             dv_v_reg [0:DV_N];
    logic [63:0]      dv_r_reg [0:DV_N];
    logic [63:0]      dv_d_reg [0:DV_N];
    logic [DV_N-1:0]  dv_q_reg [0:DV_N];
    logic             dv_z_reg [0:DV_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= ex_v_reg[EX_N];
    end

    always_ff @(posedge clk)
    begin
        dv_r_reg[0] <= n_next;
        dv_d_reg[0] <= d_next;
        dv_q_reg[0] <= '0;
        dv_z_reg[0] <= ex_z_reg[EX_N];
    end

    // restoring division, one quotient bit a stage
    for (genvar j = 1; j <= DV_N; j++)
    begin : g_dv
        localparam int B = DV_N - j;
        logic take;

        assign take = (dv_r_reg[j-1] >> B) >= dv_d_reg[j-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j] <= 1'b0;
            else
                dv_v_reg[j] <= dv_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[j] <= take ? dv_r_reg[j-1] - (dv_d_reg[j-1] << B) : dv_r_reg[j-1];
            dv_q_reg[j] <= dv_q_reg[j-1] | (take ? (DV_N'(1) << B) : '0);
            dv_d_reg[j] <= dv_d_reg[j-1];
            dv_z_reg[j] <= dv_z_reg[j-1];
        end
    end

    logic            ov_reg;
    logic [DV_N-1:0] l_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= dv_v_reg[DV_N];
    end

    // zero magnitude: 0^a is 0 for a > 0, 1 for a = 0
    always_ff @(posedge clk)
    begin
        if (dv_z_reg[DV_N])
            l_reg <= (a != 16'd0) ? DV_N'(33554432) : DV_N'(16777216);
        else
            l_reg <= dv_q_reg[DV_N];
    end

    assign out_valid = ov_reg;
    assign l         = l_reg;

endmodule

`default_nettype wire

FILE: design/complex_to_rgb_domain_color_unit.sv
// throughput: one item per clock cycle, set by the fully pipelined
//   lightness path (log2 squaring, exp2 product and divider stages)
// busy never rises and the receiver cannot stall, so no item is held
// reset clears every valid bit and sets the exponent to 1.0 (q4.12)
`default_nettype none

module complex_to_rgb_domain_color_unit #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ctrgb_pkg::in_t      sample,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data,
    output logic                     result_strobe,
    output ctrgb_pkg::out_t          result
);

    localparam int HW        = ctrgb_pkg::HUE_W;
    localparam int LW        = ctrgb_pkg::L_W;
    localparam int INV_DEPTH = ctrgb_pkg::LIGHT_LAT + 2;
    localparam int HUE_DEPTH = ctrgb_pkg::LIGHT_LAT - CORDIC_ITERATIONS;

    logic accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // exponent register, q4.12
    logic [15:0] exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_reg <= 16'd4096;
        else if (cfg_valid && cfg_ready)
            exp_reg <= cfg_data;
    end

    // squared magnitude: two squares, then their sum
    logic [31:0] ax, ay;
    logic [63:0] xx_next, yy_next;
    logic        t1v_reg, t2v_reg;
    logic [63:0] xx_reg, yy_reg, s_reg;

    assign ax      = sample.real_part[31] ? 32'd0 - sample.real_part : sample.real_part;
    assign ay      = sample.imag_part[31] ? 32'd0 - sample.imag_part : sample.imag_part;
    assign xx_next = ax * ax;
    assign yy_next = ay * ay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1v_reg <= 1'b0;
            t2v_reg <= 1'b0;
        end
        else
        begin
            t1v_reg <= accept;
            t2v_reg <= t1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        s_reg  <= xx_reg + yy_reg;
    end

    // hue path, runs alongside the magnitude path
    logic                 hue_valid;
    logic signed [HW-1:0] hue;

    ctrgb_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .real_part (sample.real_part),
        .imag_part (sample.imag_part),
        .out_valid (hue_valid),
        .hue       (hue)
    );

    // lightness path: 2 / (|z|^a + 1)
    logic          l_valid;
    logic [LW-1:0] light;

    ctrgb_light u_light (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t2v_reg),
        .s         (s_reg),
        .a         (exp_reg),
        .out_valid (l_valid),
        .l         (light)
    );

    // hue delay line so hue meets its lightness; the valid bit of the
    // lightness path marks the aligned pair
    logic signed [HW-1:0] hd_reg [0:HUE_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (hue_valid)
            hd_reg[0] <= hue;
        else
            hd_reg[0] <= hue;
        for (int i = 1; i < HUE_DEPTH; i++)
            hd_reg[i] <= hd_reg[i-1];
    end

    // invalid flag rides along with the item
    logic id_reg [0:INV_DEPTH-1];

    always_ff @(posedge clk)
    begin
        id_reg[0] <= sample.sample_invalid;
        for (int i = 1; i < INV_DEPTH; i++)
            id_reg[i] <= id_reg[i-1];
    end

    // q = min(l, 1), p = l - q; q - p never goes negative
    logic [LW-1:0] q_c, p_c, diff_c;

    always_comb
    begin
        q_c    = (light < LW'(16777216)) ? light : LW'(16777216);
        p_c    = light - q_c;
        diff_c = q_c - p_c;
    end

    logic c1v_reg, c2v_reg, c3v_reg;
    logic c1i_reg, c2i_reg;
    logic [7:0] ch_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1v_reg <= 1'b0;
            c2v_reg <= 1'b0;
            c3v_reg <= 1'b0;
        end
        else
        begin
            c1v_reg <= l_valid;
            c2v_reg <= c1v_reg;
            c3v_reg <= c2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1i_reg <= id_reg[INV_DEPTH-1];
        c2i_reg <= c1i_reg;
    end

    // per channel: hue ramp factor, blend, scale to 8 bits (128 for an invalid sample)
    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        logic signed [20:0] hs;
        logic [19:0]        hh;
        logic [16:0]        f_c;
        logic [LW-1:0]      cp_reg, cd_reg, cc_reg;
        logic [16:0]        cf_reg;
        logic [41:0]        prod;
        logic [LW-1:0]      c_next;
        logic [33:0]        sc;
        logic [9:0]         r;

        always_comb
        begin
            hs = $signed({1'b0, ctrgb_pkg::chan_offset(2'(c)), 16'b0})
                 + 21'(hd_reg[HUE_DEPTH-1]);
            hh = hs[19:0];
            // modulo 6, at most two turns back
            if (hh >= 6 * ctrgb_pkg::HUE_ONE)
                hh = hh - 20'(6 * ctrgb_pkg::HUE_ONE);
            if (hh >= 6 * ctrgb_pkg::HUE_ONE)
                hh = hh - 20'(6 * ctrgb_pkg::HUE_ONE);
            if (hh < ctrgb_pkg::HUE_ONE)
                f_c = hh[16:0];
            else if (hh < 3 * ctrgb_pkg::HUE_ONE)
                f_c = 17'd65536;
            else if (hh < 4 * ctrgb_pkg::HUE_ONE)
                f_c = 17'(4 * ctrgb_pkg::HUE_ONE - hh);
            else
                f_c = 17'd0;
        end

        // blend product at full width, then back to q.24
        assign prod   = {16'b0, cd_reg} * {25'b0, cf_reg};
        assign c_next = cp_reg + LW'(prod >> 16);
        assign sc     = ({8'b0, cc_reg} << 8) - {8'b0, cc_reg} + 34'd8388608;
        assign r      = sc[33:24];

        always_ff @(posedge clk)
        begin
            cp_reg <= p_c;
            cd_reg <= diff_c;
            cf_reg <= f_c;
            cc_reg <= c_next;
            if (c2i_reg)
                ch_reg[c] <= 8'd128;
            else if (r > 10'd255)
                ch_reg[c] <= 8'd255;
            else
                ch_reg[c] <= r[7:0];
        end
    end

    assign result_strobe = c3v_reg;
    assign result.red    = ch_reg[ctrgb_pkg::CH_RED];
    assign result.green  = ch_reg[ctrgb_pkg::CH_GREEN];
    assign result.blue   = ch_reg[ctrgb_pkg::CH_BLUE];

endmodule

`default_nettype wire
